// ===== hdl/mt19937_random_generator_top_assert.svh =====
// Assertion macros for the generator top level.
`ifndef MT19937_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MTRG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtrg assertion failed");
`define MTRG_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("mtrg forbidden condition seen");
`else
`define MTRG_ASSERT(lbl, clk, rst_n, prop)
`define MTRG_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ===== hdl/mtrg_pkg.sv =====
package mtrg_pkg;

  localparam int unsigned STATE_SIZE   = 624;
  localparam int unsigned ADDR_W       = $clog2(STATE_SIZE);
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned FAR_WRAP     = STATE_SIZE - TWIST_OFFSET;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

  localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(STATE_SIZE - 1);
  localparam logic [ADDR_W-1:0] IDX_FULL = ADDR_W'(STATE_SIZE);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_INIT,
    ST_TW_CUR,
    ST_TW_RDN,
    ST_TW_RDF,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NXT,
    RD_FAR,
    RD_POS
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    seed_load;
    logic    seed_mul;
    logic    seed_wr;
    logic    tw_init;
    logic    tw_cur;
    logic    tw_rdf;
    logic    tw_wr;
    logic    draw_out;
    logic    rd_en;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic spent;
  } status_t;

endpackage

// ===== hdl/mtrg_ram.sv =====
module mtrg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mtrg_ctrl.sv =====
module mtrg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             operation_i,
  input  mtrg_pkg::status_t status_i,
  output mtrg_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import mtrg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (operation_i) begin
            cmd_o.seed_load = 1'b1;
            state_d = ST_SEED_MUL;
          end else if (status_i.spent) begin
            state_d = ST_TW_INIT;
          end else begin
            state_d = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_MUL: begin
        cmd_o.seed_mul = 1'b1;
        state_d = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd_o.seed_wr = 1'b1;
        state_d = status_i.idx_last ? ST_IDLE : ST_SEED_MUL;
      end
      ST_TW_INIT: begin
        cmd_o.tw_init = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_ZERO;
        state_d = ST_TW_CUR;
      end
      ST_TW_CUR: begin
        cmd_o.tw_cur = 1'b1;
        state_d = ST_TW_RDN;
      end
      ST_TW_RDN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_NXT;
        state_d = ST_TW_RDF;
      end
      ST_TW_RDF: begin
        cmd_o.tw_rdf = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_FAR;
        state_d = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd_o.tw_wr = 1'b1;
        state_d = status_i.idx_last ? ST_DRAW_RD : ST_TW_RDN;
      end
      ST_DRAW_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_POS;
        state_d = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        cmd_o.draw_out = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== hdl/mtrg_datapath.sv =====
module mtrg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       seed_value_i,
  input  logic [5:0]        bits_i,
  input  mtrg_pkg::cmd_t    cmd_i,
  output mtrg_pkg::status_t status_o,
  output logic [31:0]       random_value_o,
  output logic              random_value_valid_o
);
  import mtrg_pkg::*;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [ADDR_W-1:0] idx_q, pos_q;
  logic [31:0]       prev_q, mul_q, cur_q, nxt_q, out_q;
  logic [5:0]        bits_q;
  logic              valid_q;

  logic [ADDR_W-1:0] nxt_idx, far_idx, raddr, waddr;
  logic [31:0]       rdata, wdata, seed_word, mix, twisted, tempered, shaped, prev_mix;
  logic [4:0]        shamt;
  logic              we;

  assign nxt_idx = (idx_q == IDX_LAST) ? '0 : idx_q + ADDR_W'(1);
  assign far_idx = (idx_q < ADDR_W'(FAR_WRAP)) ? idx_q + ADDR_W'(TWIST_OFFSET)
                                                 : idx_q - ADDR_W'(FAR_WRAP);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO: raddr = '0;
      RD_NXT:  raddr = nxt_idx;
      RD_FAR:  raddr = far_idx;
      RD_POS:  raddr = pos_q;
      default: raddr = '0;
    endcase
  end

  assign prev_mix  = prev_q ^ (prev_q >> 30);
  assign seed_word = mul_q + {{(32-ADDR_W){1'b0}}, idx_q};
  assign mix       = {cur_q[31], nxt_q[30:0]};
  assign twisted   = rdata ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'd0);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = twisted;
    if (cmd_i.seed_load) begin
      we    = 1'b1;
      waddr = '0;
      wdata = seed_value_i;
    end else if (cmd_i.seed_wr) begin
      we    = 1'b1;
      wdata = seed_word;
    end else if (cmd_i.tw_wr) begin
      we    = 1'b1;
    end
  end

  mtrg_ram #(
    .WIDTH(32),
    .DEPTH(STATE_SIZE)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign tempered = temper(rdata);
  assign shamt    = 5'(6'd32 - bits_q);

  always_comb begin
    if (bits_q == 6'd0) begin
      shaped = '0;
    end else if (bits_q >= 6'd32) begin
      shaped = tempered;
    end else begin
      shaped = tempered >> shamt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= IDX_FULL;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.draw_out;
      if (cmd_i.seed_load) begin
        idx_q <= ADDR_W'(1);
        pos_q <= IDX_FULL;
      end else if (cmd_i.seed_wr || cmd_i.tw_wr) begin
        idx_q <= idx_q + ADDR_W'(1);
        if (cmd_i.tw_wr && status_o.idx_last) begin
          pos_q <= '0;
        end
      end else if (cmd_i.tw_init) begin
        idx_q <= '0;
      end else if (cmd_i.draw_out) begin
        pos_q <= pos_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bits_q <= bits_i;
    end
    if (cmd_i.seed_load) begin
      prev_q <= seed_value_i;
    end else if (cmd_i.seed_wr) begin
      prev_q <= seed_word;
    end
    if (cmd_i.seed_mul) begin
      mul_q <= 32'(INIT_MULT * prev_mix);
    end
    if (cmd_i.tw_cur) begin
      cur_q <= rdata;
    end else if (cmd_i.tw_wr) begin
      cur_q <= nxt_q;
    end
    if (cmd_i.tw_rdf) begin
      nxt_q <= rdata;
    end
    if (cmd_i.draw_out) begin
      out_q <= shaped;
    end
  end

  assign status_o.idx_last    = (idx_q == IDX_LAST);
  assign status_o.spent       = (pos_q >= IDX_FULL);
  assign random_value_o       = out_q;
  assign random_value_valid_o = valid_q;

endmodule

// ===== hdl/mt19937_random_generator_top.sv =====
// MT19937-32 generator. Issue a word with start high while busy is low; the word is
// taken at that edge. operation_i = 1 reseeds from seed_value_i and gives no result;
// it keeps busy high through one 32x32 multiply and one state RAM write per state
// word after the first. operation_i = 0 draws: random_value_o holds the top bits_i
// bits (all 32 above 32) of the next tempered word and random_value_valid_o is high
// for exactly one cycle, after ST_DRAW_RD, ST_DRAW_OUT and valid_q. There is no
// back-pressure on the result, so the receiver must take it in that cycle. The first
// draw after a seed, and every 624th draw after it, first twists the state: two RAM
// reads, one write per word. The first word after reset must be a reseed.
module mt19937_random_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [31:0] seed_value_i,
  input  logic [5:0]  bits_i,
  output logic [31:0] random_value_o,
  output logic        random_value_valid_o
);
  import mtrg_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  mtrg_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .seed_value_i        (seed_value_i),
    .bits_i              (bits_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .random_value_o      (random_value_o),
    .random_value_valid_o(random_value_valid_o)
  );

`include "mt19937_random_generator_top_assert.svh"

  `MTRG_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `MTRG_ASSERT(a_strobe_single, clk_i, rst_ni, random_value_valid_o |=> !random_value_valid_o)
  `MTRG_ASSERT(a_result_after_work, clk_i, rst_ni, random_value_valid_o |-> $past(busy))
  `MTRG_ASSERT_NEVER(a_no_twist_when_idle, clk_i, rst_ni, !busy && cmd.tw_wr)

endmodule
